/* sv/tccs_pkg.sv */
// package: geometry, codes, word types and control structs of the text console unit
`default_nettype none

package tccs_pkg;

    // screen geometry
    localparam int WIDTH      = 80;
    localparam int HEIGHT     = 25;
    localparam int CELLS      = WIDTH * HEIGHT;
    localparam int COPY_LEN   = (HEIGHT - 2) * WIDTH;
    localparam int SCROLL_END = (HEIGHT - 1) * WIDTH;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int CNT_W      = $clog2(CELLS + 1);

    // fixed field widths
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int POS_W   = 11;
    localparam int CELL_W  = 16;
    localparam int LIN_W   = ROW_W + COL_W;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // character codes
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // register reset values
    localparam logic [3:0] RESET_FG = 4'd7;
    localparam logic [3:0] RESET_BG = 4'd0;
    localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_BG, RESET_FG, CH_SPACE};

    // register indexes
    localparam logic REG_FG = 1'b0;
    localparam logic REG_BG = 1'b1;

    typedef enum logic [1:0] {
        FN_PUT   = 2'd0,
        FN_CLEAR = 2'd1,
        FN_READ  = 2'd2,
        FN_WRITE = 2'd3
    } func_t;

    typedef struct packed {
        func_t            func;
        logic [7:0]       ch;
        logic [7:0]       attribute;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } req_t;

    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic [POS_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] cell_data;
        logic              scrolled;
        logic              write_done;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic fill;
        logic init;
        logic scroll;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        func_t func;
        logic  need_scroll;
        logic  fill_last;
        logic  scroll_last;
    } dp_stat_t;

endpackage

`default_nettype wire

/* sv/tccs_ram.sv */
// generic single write port, single read port ram with registered read
`default_nettype none

module tccs_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/tccs_regs.sv */
// configuration registers: default colors of blank cells
`default_nettype none

module tccs_regs
    import tccs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic      [CELL_W-1:0]  blank
);

    logic [3:0] fg_reg;
    logic [3:0] bg_reg;
    logic       wr_en;
    logic       sel;

    assign wr_en = psel && penable && pwrite;
    assign sel   = paddr[2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= RESET_FG;
            bg_reg <= RESET_BG;
        end
        else if (wr_en)
        begin
            case (sel)
                REG_FG:  fg_reg <= pwdata[3:0];
                REG_BG:  bg_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (sel)
            REG_FG:  prdata = PDATA_W'(fg_reg);
            REG_BG:  prdata = PDATA_W'(bg_reg);
            default: prdata = '0;
        endcase
    end

    assign blank = {bg_reg, fg_reg, CH_SPACE};

endmodule

`default_nettype wire

/* sv/tccs_ctrl.sv */
// controller: sequences each operation word and the cell store sweeps
`default_nettype none

module tccs_ctrl
    import tccs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_SCROLL,
        ST_RDWAIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.fill = 1'b1;
                cmd.init = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                case (stat.func)
                    FN_PUT:
                    begin
                        if (stat.need_scroll)
                        begin
                            state_next = ST_SCROLL;
                        end
                        else
                        begin
                            cmd.finish = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    FN_CLEAR: state_next = ST_FILL;
                    FN_READ:  state_next = ST_RDWAIT;
                    default:
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_FILL:
            begin
                cmd.fill = 1'b1;
                if (stat.fill_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCROLL:
            begin
                cmd.scroll = 1'b1;
                if (stat.scroll_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RDWAIT:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

/* sv/tccs_dp.sv */
// datapath: cursor, request word, cell store, sweep counter and result word
`default_nettype none

module tccs_dp
    import tccs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire req_t              req,
    input  wire logic [CELL_W-1:0] blank,
    input  wire dp_cmd_t           cmd,
    output dp_stat_t               stat,
    output logic                   done,
    output rsp_t                   rsp
);

    req_t              req_reg;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [ROW_W-1:0]  cur_row_next;
    logic [COL_W-1:0]  cur_col_reg;
    logic [COL_W-1:0]  cur_col_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              wd_pend_reg;
    logic              wd_pend_next;
    logic              scr_pend_reg;
    logic              scr_pend_next;
    logic              done_reg;
    rsp_t              rsp_reg;

    logic              is_put;
    logic              is_clear;
    logic              is_read;
    logic              is_write;
    logic              in_range;
    logic [ROW_W-1:0]  pc_row;
    logic [COL_W-1:0]  pc_col;
    logic              pc_wd;
    logic              pc_scroll;
    logic [ROW_W-1:0]  addr_row;
    logic [COL_W-1:0]  addr_col;
    logic [LIN_W-1:0]  cell_lin;
    logic [LIN_W-1:0]  pos_lin;
    logic [CNT_W-1:0]  cnt_src;
    logic [CNT_W-1:0]  cnt_m1;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    // operation decode
    assign is_put   = (req_reg.func == FN_PUT);
    assign is_clear = (req_reg.func == FN_CLEAR);
    assign is_read  = (req_reg.func == FN_READ);
    assign is_write = (req_reg.func == FN_WRITE);
    assign in_range = (req_reg.row < ROW_W'(HEIGHT)) && (req_reg.col < COL_W'(WIDTH));

    // put char cursor movement, wrap and scroll decision
    always_comb
    begin
        logic [ROW_W-1:0] r;
        logic [COL_W:0]   c;
        r     = cur_row_reg;
        c     = {1'b0, cur_col_reg};
        pc_wd = 1'b0;
        if (req_reg.ch == CH_BS)
        begin
            if (cur_col_reg != '0)
            begin
                c = c - 1'b1;
            end
            else if (cur_row_reg != '0)
            begin
                r = r - 1'b1;
                c = (COL_W+1)'(WIDTH - 1);
            end
        end
        else if (req_reg.ch == CH_LF)
        begin
            c = '0;
            r = r + 1'b1;
        end
        else
        begin
            pc_wd = 1'b1;
            c     = c + 1'b1;
        end
        if (c >= (COL_W+1)'(WIDTH))
        begin
            c = '0;
            r = r + 1'b1;
        end
        pc_scroll = (r >= ROW_W'(HEIGHT - 1));
        if (pc_scroll)
        begin
            r = ROW_W'(HEIGHT - 2);
            c = '0;
        end
        pc_row = r;
        pc_col = c[COL_W-1:0];
    end

    // cell address of the cursor or the requested position
    assign addr_row = is_put ? cur_row_reg : req_reg.row;
    assign addr_col = is_put ? cur_col_reg : req_reg.col;
    assign cell_lin = LIN_W'(addr_row) * LIN_W'(WIDTH) + LIN_W'(addr_col);

    // sweep addresses
    assign cnt_src = cnt_reg + CNT_W'(WIDTH);
    assign cnt_m1  = cnt_reg - 1'b1;

    // cell store port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        if (cmd.exec)
        begin
            if ((is_put && pc_wd) || (is_write && in_range))
            begin
                ram_we    = 1'b1;
                ram_waddr = cell_lin[ADDR_W-1:0];
                ram_wdata = {req_reg.attribute, req_reg.ch};
            end
            if (is_read && in_range)
            begin
                ram_re    = 1'b1;
                ram_raddr = cell_lin[ADDR_W-1:0];
            end
        end
        if (cmd.fill)
        begin
            ram_we    = 1'b1;
            ram_waddr = cnt_reg[ADDR_W-1:0];
            ram_wdata = cmd.init ? RESET_BLANK : blank;
        end
        if (cmd.scroll)
        begin
            // read one row below, write it back in the next cycle, then blank a row
            ram_re    = (cnt_reg < CNT_W'(COPY_LEN));
            ram_raddr = cnt_src[ADDR_W-1:0];
            ram_we    = (cnt_reg != '0);
            ram_waddr = cnt_m1[ADDR_W-1:0];
            ram_wdata = (cnt_reg <= CNT_W'(COPY_LEN)) ? ram_rdata : blank;
        end
    end

    tccs_ram #(
        .DATA_W (CELL_W),
        .DEPTH  (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // cursor and pending flag update
    always_comb
    begin
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        wd_pend_next  = wd_pend_reg;
        scr_pend_next = scr_pend_reg;
        if (cmd.exec)
        begin
            scr_pend_next = is_put && pc_scroll;
            wd_pend_next  = (is_put && pc_wd) || is_clear || (is_write && in_range);
            if (is_put)
            begin
                cur_row_next = pc_row;
                cur_col_next = pc_col;
            end
            else if (is_clear)
            begin
                cur_row_next = '0;
                cur_col_next = '0;
            end
        end
    end

    // sweep counter
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.exec)
        begin
            cnt_next = '0;
        end
        else if (cmd.fill || cmd.scroll)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    assign pos_lin = LIN_W'(cur_row_next) * LIN_W'(WIDTH) + LIN_W'(cur_col_next);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg  <= '0;
            cur_col_reg  <= '0;
            cnt_reg      <= '0;
            wd_pend_reg  <= 1'b0;
            scr_pend_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            cur_row_reg  <= cur_row_next;
            cur_col_reg  <= cur_col_next;
            cnt_reg      <= cnt_next;
            wd_pend_reg  <= wd_pend_next;
            scr_pend_reg <= scr_pend_next;
            done_reg     <= cmd.finish;
        end
    end

    // request word and result word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.finish)
        begin
            rsp_reg.cursor_row <= cur_row_next;
            rsp_reg.cursor_col <= cur_col_next;
            rsp_reg.cursor_pos <= pos_lin[POS_W-1:0];
            rsp_reg.cell_data  <= (is_read && in_range) ? ram_rdata : '0;
            rsp_reg.scrolled   <= scr_pend_next;
            rsp_reg.write_done <= wd_pend_next;
        end
    end

    // status to the controller
    assign stat.func        = req_reg.func;
    assign stat.need_scroll = pc_scroll;
    assign stat.fill_last   = (cnt_reg == CNT_W'(CELLS - 1));
    assign stat.scroll_last = (cnt_reg == CNT_W'(SCROLL_END));

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

/* sv/text_console_cursor_scroll_unit.sv */
// top level: text console engine with cursor, scroll and cell store
// put char and write-at finish in the execute state; a read then passes a wait state for the
// registered store read; clear and a put char that scrolls run a sweep of the cell store first;
// the sweeps run one cell per cycle through the single write port of the cell store.
// no new word is taken while busy, and busy is high until done.
// reset: cursor homes, colors return to defaults, then a clearing pass over all WIDTH*HEIGHT
// cells blanks the store with busy high; results cannot be stalled by the receiver.
`default_nettype none

module text_console_cursor_scroll_unit
    import tccs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire req_t               req,
    output logic                    done,
    output rsp_t                    rsp,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [CELL_W-1:0] blank;

    assign pready = 1'b1;

    // configuration registers
    tccs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .blank   (blank)
    );

    // controller
    tccs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // datapath
    tccs_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .blank (blank),
        .cmd   (cmd),
        .stat  (stat),
        .done  (done),
        .rsp   (rsp)
    );

    // a result only follows work in progress
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a word in progress");

    // the engine is free again when the result shows
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while still busy");

    // no result in the cycle right after a word is accepted
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result too early after accept");

    // reported cursor stays above the bottom row and inside the width
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((rsp.cursor_col < COL_W'(WIDTH)) && (rsp.cursor_row <= ROW_W'(HEIGHT - 2))))
        else $error("cursor out of range");

endmodule

`default_nettype wire
